>>> rtl/multidim_array_access_top_assert.svh
// ----------------------------------------------------------------------------
// multidim_array_access_top_assert.svh
// assertion macros used by the checker of the array store
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_ARRAY_ACCESS_TOP_ASSERT_SVH
`define MULTIDIM_ARRAY_ACCESS_TOP_ASSERT_SVH

// condition in the same cycle as the trigger
`define MAA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("array store check failed in trigger cycle");

// condition in the cycle after the trigger
`define MAA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("array store check failed one cycle after trigger");

`endif

>>> rtl/maa_pkg.sv
// ----------------------------------------------------------------------------
// maa_pkg
// types and constants shared by the multi-dimensional array store
// ----------------------------------------------------------------------------
package maa_pkg;

    // geometry
    localparam int unsigned NUM_DIMS    = 4;
    localparam int unsigned DIM_W       = 2;
    localparam int unsigned DCNT_W      = 3;
    localparam int unsigned IDX_W       = 12;
    localparam int unsigned LEN_W       = 13;
    localparam int unsigned ELEM_W      = 32;
    localparam int unsigned OFF_W       = 12;
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned PROD_W      = LEN_W + IDX_W;
    localparam int unsigned SUM_W       = PROD_W + DIM_W;
    localparam int unsigned SPROD_W     = 2 * LEN_W;

    // configuration port
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned RSEL_W = 3;

    localparam logic [RSEL_W-1:0] REG_NUM_DIMS = 3'd0;
    localparam logic [RSEL_W-1:0] REG_LEN_DIM0 = 3'd1;
    localparam logic [RSEL_W-1:0] REG_LEN_DIM1 = 3'd2;
    localparam logic [RSEL_W-1:0] REG_LEN_DIM2 = 3'd3;
    localparam logic [RSEL_W-1:0] REG_LEN_DIM3 = 3'd4;

    localparam logic [DCNT_W-1:0] NUM_DIMS_RST = 3'd1;
    localparam logic [LEN_W-1:0]  LEN0_RST     = 13'd4096;
    localparam logic [LEN_W-1:0]  LEN_RST      = 13'd1;

    // queue depths
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned RESQ_DEPTH = 4;
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned QCNT_W     = 3;

    typedef logic [LEN_W-1:0] t_len;
    typedef t_len [NUM_DIMS-1:0] t_len_vec;
    typedef logic [IDX_W-1:0] t_idx;
    typedef t_idx [NUM_DIMS-1:0] t_idx_vec;

    // view of the configuration seen by the front
    typedef struct packed {
        logic              busy;
        logic [DCNT_W-1:0] dims;
        t_len_vec          lens;
        t_len_vec          strides;
    } t_geom;

    // classified access handed to the back
    typedef struct packed {
        logic              is_write;
        logic              bad;
        logic [OFF_W-1:0]  offset;
        logic [ELEM_W-1:0] wdata;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [ELEM_W-1:0] read_value;
        logic [OFF_W-1:0]  element_offset;
        logic              status;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC
    } t_stride_state;

endpackage

>>> rtl/maa_cfg.sv
// ----------------------------------------------------------------------------
// maa_cfg
// configuration registers and sequential row-major stride derivation
// ----------------------------------------------------------------------------
module maa_cfg import maa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output t_geom             o_geom
);

    logic [DCNT_W-1:0] r_num_dims;
    t_len_vec          r_len;
    t_len_vec          r_stride;
    t_len_vec          n_stride;
    logic [DIM_W-1:0]  r_idx;
    logic [DIM_W-1:0]  n_idx;
    t_stride_state     r_state;
    t_stride_state     n_state;
    logic              wr;
    logic [RSEL_W-1:0] rsel;
    logic [DCNT_W-1:0] used;
    logic [DIM_W-1:0]  last;
    logic [SPROD_W-1:0] sprod;
    t_len              ssat;

    assign wr   = i_psel && i_penable && i_pwrite;
    assign rsel = i_paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RST;
            r_len[0]   <= LEN0_RST;
            r_len[1]   <= LEN_RST;
            r_len[2]   <= LEN_RST;
            r_len[3]   <= LEN_RST;
        end else if (wr) begin
            unique case (rsel)
                REG_NUM_DIMS: r_num_dims <= i_pwdata[DCNT_W-1:0];
                REG_LEN_DIM0: r_len[0]   <= i_pwdata[LEN_W-1:0];
                REG_LEN_DIM1: r_len[1]   <= i_pwdata[LEN_W-1:0];
                REG_LEN_DIM2: r_len[2]   <= i_pwdata[LEN_W-1:0];
                REG_LEN_DIM3: r_len[3]   <= i_pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        o_prdata = '0;
        unique case (rsel)
            REG_NUM_DIMS: o_prdata = DATA_W'(r_num_dims);
            REG_LEN_DIM0: o_prdata = DATA_W'(r_len[0]);
            REG_LEN_DIM1: o_prdata = DATA_W'(r_len[1]);
            REG_LEN_DIM2: o_prdata = DATA_W'(r_len[2]);
            REG_LEN_DIM3: o_prdata = DATA_W'(r_len[3]);
            default:      o_prdata = '0;
        endcase
    end

    // dimensions in use, clamped to one..four
    always_comb begin
        used = r_num_dims;
        if (r_num_dims == '0) begin
            used = DCNT_W'(1);
        end else if (r_num_dims > DCNT_W'(NUM_DIMS)) begin
            used = DCNT_W'(NUM_DIMS);
        end
        last = DIM_W'(used - DCNT_W'(1));
    end

    // one stride step: next length times next stride, saturated at the store depth
    assign sprod = SPROD_W'(r_len[r_idx]) * SPROD_W'(r_stride[r_idx]);
    assign ssat  = (sprod > SPROD_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : sprod[LEN_W-1:0];

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // stride table and step index
    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
        r_idx    <= n_idx;
    end

    // next state, stride and index
    always_comb begin
        n_state  = r_state;
        n_stride = r_stride;
        n_idx    = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_LOAD: begin
                n_stride       = '0;
                n_stride[last] = LEN_W'(1);
                n_idx          = last;
                n_state        = (last == '0) ? ST_IDLE : ST_CALC;
            end
            ST_CALC: begin
                n_stride[DIM_W'(r_idx - DIM_W'(1))] = ssat;
                n_idx   = DIM_W'(r_idx - DIM_W'(1));
                n_state = (r_idx == DIM_W'(1)) ? ST_IDLE : ST_CALC;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        // any register write restarts the derivation
        if (wr) begin
            n_state = ST_LOAD;
        end
    end

    assign o_geom.busy    = (r_state != ST_IDLE);
    assign o_geom.dims    = used;
    assign o_geom.lens    = r_len;
    assign o_geom.strides = r_stride;

endmodule

>>> rtl/maa_cmdq.sv
// ----------------------------------------------------------------------------
// maa_cmdq
// short queue of classified accesses between front and back
// ----------------------------------------------------------------------------
module maa_cmdq import maa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd              r_entry [CMDQ_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_entry[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= QPTR_W'(r_wptr + QPTR_W'(1));
            end
            if (do_pop) begin
                r_rptr <= QPTR_W'(r_rptr + QPTR_W'(1));
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= QCNT_W'(r_cnt + QCNT_W'(1));
                2'b01:   r_cnt <= QCNT_W'(r_cnt - QCNT_W'(1));
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/maa_front.sv
// ----------------------------------------------------------------------------
// maa_front
// accepts items, checks subscripts and forms the row-major offset in two stages
// ----------------------------------------------------------------------------
module maa_front import maa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_action,
    input  t_idx_vec          i_index,
    input  logic [ELEM_W-1:0] i_write_value,
    output logic              o_cmd_push,
    output t_cmd              o_cmd,
    input  logic              i_cmdq_full
);

    logic                           r_s1_v;
    logic                           r_s1_write;
    logic                           r_s1_bad;
    logic [NUM_DIMS-1:0][PROD_W-1:0] r_s1_prod;
    logic [ELEM_W-1:0]              r_s1_wdata;
    logic                           r_s2_v;
    t_cmd                           r_s2_cmd;

    logic                           s1_en;
    logic                           s2_en;
    logic                           accept;
    logic [NUM_DIMS-1:0]            lane_bad;
    logic [NUM_DIMS-1:0][PROD_W-1:0] lane_prod;
    logic [SUM_W-1:0]               sum;
    logic                           s2_bad;
    t_cmd                           s2_cmd;

    // stage enables, stalled back from the queue
    assign s2_en      = !r_s2_v || !i_cmdq_full;
    assign s1_en      = !r_s1_v || s2_en;
    assign o_full     = i_geom.busy || !s1_en;
    assign accept     = i_push && !o_full;
    assign o_cmd_push = r_s2_v && !i_cmdq_full;
    assign o_cmd      = r_s2_cmd;

    // per-dimension bound check and stride product
    always_comb begin
        for (int k = 0; k < NUM_DIMS; k++) begin
            if (DCNT_W'(k) < i_geom.dims) begin
                lane_bad[k]  = ({1'b0, i_index[k]} >= i_geom.lens[k]);
                lane_prod[k] = PROD_W'(i_geom.strides[k]) * PROD_W'(i_index[k]);
            end else begin
                lane_bad[k]  = 1'b0;
                lane_prod[k] = '0;
            end
        end
    end

    // offset sum and store range check
    always_comb begin
        sum = '0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            sum = SUM_W'(sum + SUM_W'(r_s1_prod[k]));
        end
        s2_bad          = r_s1_bad || (sum >= SUM_W'(STORE_DEPTH));
        s2_cmd.is_write = r_s1_write;
        s2_cmd.bad      = s2_bad;
        s2_cmd.offset   = s2_bad ? '0 : sum[OFF_W-1:0];
        s2_cmd.wdata    = r_s1_wdata;
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_v <= accept;
            end
            if (s2_en) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (s1_en && accept) begin
            r_s1_write <= i_action;
            r_s1_bad   <= |lane_bad;
            r_s1_prod  <= lane_prod;
            r_s1_wdata <= i_write_value;
        end
        if (s2_en && r_s1_v) begin
            r_s2_cmd <= s2_cmd;
        end
    end

endmodule

>>> rtl/maa_back.sv
// ----------------------------------------------------------------------------
// maa_back
// element store access and result queue
// ----------------------------------------------------------------------------
module maa_back import maa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    logic [ELEM_W-1:0] r_mem [STORE_DEPTH];
    logic [ELEM_W-1:0] r_rdata;
    logic              r_v;
    t_cmd              r_cmd;
    t_res              r_resq [RESQ_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;
    logic              mem_we;
    t_res              res;

    // take a command only while its result is sure of a slot
    assign o_cmd_pop = !i_cmd_empty
                       && (({1'b0, r_cnt} + (QCNT_W + 1)'(r_v)) < (QCNT_W + 1)'(RESQ_DEPTH));
    assign mem_we    = o_cmd_pop && i_cmd.is_write && !i_cmd.bad;

    // element store, one port, registered read
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            if (mem_we) begin
                r_mem[i_cmd.offset] <= i_cmd.wdata;
            end
            r_rdata <= r_mem[i_cmd.offset];
        end
    end

    // access stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= o_cmd_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // result formatting
    always_comb begin
        res.read_value     = (!r_cmd.is_write && !r_cmd.bad) ? r_rdata : '0;
        res.element_offset = r_cmd.offset;
        res.status         = r_cmd.bad;
    end

    // result queue
    assign o_empty = (r_cnt == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_res   = r_resq[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_v) begin
                r_wptr <= QPTR_W'(r_wptr + QPTR_W'(1));
            end
            if (do_pop) begin
                r_rptr <= QPTR_W'(r_rptr + QPTR_W'(1));
            end
            case ({r_v, do_pop})
                2'b10:   r_cnt <= QCNT_W'(r_cnt + QCNT_W'(1));
                2'b01:   r_cnt <= QCNT_W'(r_cnt - QCNT_W'(1));
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_resq[r_wptr] <= res;
        end
    end

endmodule

>>> rtl/multidim_array_access_top.sv
// ----------------------------------------------------------------------------
// multidim_array_access_top
// row-major mapped four-dimensional array store with queue-style ports
// ----------------------------------------------------------------------------
// an item passes front stages s1 and s2, the command queue and the store access stage
// throughput: one item per cycle while full is low, set by the single-port element store
// after reset and after every register write the stride sequencer runs one load step
// plus one multiply per extra dimension, with full high
// reset is synchronous, active low; element store contents are not cleared
module multidim_array_access_top import maa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // items
    input  logic                     push,
    output logic                     full,
    input  logic                     i_action,
    input  logic [IDX_W-1:0]         i_index0,
    input  logic [IDX_W-1:0]         i_index1,
    input  logic [IDX_W-1:0]         i_index2,
    input  logic [IDX_W-1:0]         i_index3,
    input  logic signed [ELEM_W-1:0] i_write_value,
    // results
    output logic                     empty,
    input  logic                     pop,
    output logic signed [ELEM_W-1:0] o_read_value,
    output logic [OFF_W-1:0]         o_element_offset,
    output logic                     o_status
);

    t_geom    geom;
    t_idx_vec index;
    logic     cmd_push;
    logic     cmd_pop;
    logic     cmdq_full;
    logic     cmdq_empty;
    t_cmd     cmd_in;
    t_cmd     cmd_out;
    t_res     res;

    assign pready = 1'b1;
    assign index  = {i_index3, i_index2, i_index1, i_index0};

    // registers and strides
    maa_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_geom    (geom)
    );

    // classification
    maa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_index       (index),
        .i_write_value (i_write_value),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .i_cmdq_full   (cmdq_full)
    );

    // decoupling queue
    maa_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmdq_empty)
    );

    // store access
    maa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmdq_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_read_value     = res.read_value;
    assign o_element_offset = res.element_offset;
    assign o_status         = res.status;

endmodule

>>> rtl/maa_checker.sv
// ----------------------------------------------------------------------------
// maa_checker
// port-level checks of the array store, bound to the top level
// ----------------------------------------------------------------------------
`include "multidim_array_access_top_assert.svh"

module maa_checker import maa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic              i_full,
    input logic              i_empty,
    input logic              i_pop,
    input logic [ELEM_W-1:0] i_read_value,
    input logic [OFF_W-1:0]  i_element_offset,
    input logic              i_status
);

    // a failed access reports no offset and no data
    `MAA_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, !i_empty && i_status, (i_element_offset == '0) && (i_read_value == '0))

    // a waiting result is held until its transfer
    `MAA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_read_value) && $stable(i_element_offset) && $stable(i_status))

    // a register write blocks items while strides are rederived
    `MAA_ASSERT_NEXT(a_cfg_busy, i_clk, i_rst_n, i_psel && i_penable && i_pwrite, i_full)

    // strides are derived before the first item after reset
    `MAA_ASSERT_SAME(a_rst_busy, i_clk, i_rst_n, $rose(i_rst_n), i_full && i_empty)

endmodule

bind multidim_array_access_top maa_checker u_maa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_psel           (psel),
    .i_penable        (penable),
    .i_pwrite         (pwrite),
    .i_full           (full),
    .i_empty          (empty),
    .i_pop            (pop),
    .i_read_value     (o_read_value),
    .i_element_offset (o_element_offset),
    .i_status         (o_status)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the multi-dimensional array store against a row-major predictor:
// a directed table of accesses and register writes covering the edges of the
// geometry, then random phases of accesses under changing geometries, with
// random idling on both queue ports and long receiver stalls
// ----------------------------------------------------------------------------
module testbench;
    import maa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int DRAIN_LIMIT     = 2_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_PCT        = 37;
    localparam int HOLD_CYCLES     = 120;
    localparam int N_PHASES        = 11;
    localparam int ITEMS_PER_PHASE = 155;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    localparam logic [RSEL_W-1:0] LEN_REG_SEL [NUM_DIMS] =
        '{REG_LEN_DIM0, REG_LEN_DIM1, REG_LEN_DIM2, REG_LEN_DIM3};

    localparam t_res OUT_OF_RANGE = '{read_value: '0, element_offset: '0, status: STAT_RANGE};

    typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} t_access;
    typedef enum logic {ROW_CFG, ROW_ACCESS} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [RSEL_W-1:0]  sel;
        logic [DATA_W-1:0]  value;
        t_access            act;
        t_idx_vec           idx;
        logic [ELEM_W-1:0]  wval;
        bit                 typed;
        t_res               want;
    } t_step;

    // clock, reset and ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     push = 1'b0;
    logic                     full;
    logic                     i_action = 1'b0;
    logic [IDX_W-1:0]         i_index0 = '0;
    logic [IDX_W-1:0]         i_index1 = '0;
    logic [IDX_W-1:0]         i_index2 = '0;
    logic [IDX_W-1:0]         i_index3 = '0;
    logic signed [ELEM_W-1:0] i_write_value = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [ELEM_W-1:0] o_read_value;
    logic [OFF_W-1:0]         o_element_offset;
    logic                     o_status;

    // geometry and element mirror
    logic [DCNT_W-1:0] dims_cfg;
    logic [LEN_W-1:0]  len_cfg    [NUM_DIMS];
    int unsigned       stride_cfg [NUM_DIMS];
    logic [ELEM_W-1:0] elem_mirror [STORE_DEPTH];
    bit                elem_valid  [STORE_DEPTH];

    t_res pending_results [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  n_reads = 0;
    int  n_writes = 0;
    int  n_range = 0;
    int  n_reg_writes = 0;
    bit  sender_calm = 1'b0;
    bit  receiver_calm = 1'b0;
    bit  hold_request = 1'b0;

    multidim_array_access_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_index0         (i_index0),
        .i_index1         (i_index1),
        .i_index2         (i_index2),
        .i_index3         (i_index3),
        .i_write_value    (i_write_value),
        .empty            (empty),
        .pop              (pop),
        .o_read_value     (o_read_value),
        .o_element_offset (o_element_offset),
        .o_status         (o_status)
    );

    // 10 ns clock
    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // dimension count as the block applies it
    function automatic int dims_in_use();
        int d;
        d = int'(dims_cfg);
        if (d < 1) d = 1;
        if (d > NUM_DIMS) d = NUM_DIMS;
        return d;
    endfunction

    // row-major strides, saturated at the store depth
    function automatic void derive_strides();
        int d;
        longint unsigned s;
        d = dims_in_use();
        foreach (stride_cfg[i]) stride_cfg[i] = 0;
        stride_cfg[d-1] = 1;
        for (int i = d - 1; i > 0; i--) begin
            s = longint'(len_cfg[i]) * stride_cfg[i];
            if (s > STORE_DEPTH) s = STORE_DEPTH;
            stride_cfg[i-1] = int'(s);
        end
    endfunction

    // linear offset of a subscript set; returns 1 when out of range
    function automatic bit map_element(input t_idx_vec idx, output int unsigned off);
        bit bad;
        longint unsigned sum;
        bad = 1'b0;
        sum = 0;
        for (int i = 0; i < dims_in_use(); i++) begin
            if (idx[i] >= len_cfg[i]) bad = 1'b1;
            else sum += longint'(stride_cfg[i]) * idx[i];
        end
        if (!bad && sum >= STORE_DEPTH) bad = 1'b1;
        off = bad ? 0 : int'(sum);
        return bad;
    endfunction

    // expected result of one access, updating the element mirror
    function automatic t_res access_element(input t_access act, input t_idx_vec idx,
                                            input logic [ELEM_W-1:0] wval);
        t_res r;
        int unsigned off;
        r = '0;
        if (map_element(idx, off)) begin
            r.status = STAT_RANGE;
        end else begin
            r.status = STAT_OK;
            r.element_offset = OFF_W'(off);
            if (act == ACC_WRITE) begin
                elem_mirror[off] = wval;
                elem_valid[off] = 1'b1;
            end else begin
                r.read_value = elem_mirror[off];
            end
        end
        return r;
    endfunction

    function automatic t_step cfg_step(input logic [RSEL_W-1:0] sel,
                                       input logic [DATA_W-1:0] value);
        t_step s;
        s.kind = ROW_CFG;
        s.sel = sel;
        s.value = value;
        s.act = ACC_READ;
        s.idx = '0;
        s.wval = '0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic t_step access_step(input t_access act, input int i0, input int i1,
                                          input int i2, input int i3,
                                          input logic [ELEM_W-1:0] wval,
                                          input bit typed, input t_res want);
        t_step s;
        s.kind = ROW_ACCESS;
        s.sel = REG_NUM_DIMS;
        s.value = '0;
        s.act = act;
        s.idx[0] = IDX_W'(i0);
        s.idx[1] = IDX_W'(i1);
        s.idx[2] = IDX_W'(i2);
        s.idx[3] = IDX_W'(i3);
        s.wval = wval;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // register write with read-back, only once the store has gone quiet
    task automatic write_register(input logic [RSEL_W-1:0] sel, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] kept;
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        if (sel == REG_NUM_DIMS) kept = DATA_W'(value[DCNT_W-1:0]);
        else kept = DATA_W'(value[LEN_W-1:0]);
        // setup and access phases of the write
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_NUM_DIMS) dims_cfg = value[DCNT_W-1:0];
        else len_cfg[sel - REG_LEN_DIM0] = value[LEN_W-1:0];
        derive_strides();
        n_reg_writes++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== kept) begin
            $error("register %0d readback: expected %h, got %h", sel, kept, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // random idle cycles on the input side
    task automatic sender_gap();
        while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // offer one access until the block takes it, then log what it should return
    task automatic offer_access(input t_access act, input t_idx_vec idx,
                                input logic [ELEM_W-1:0] wval, input bit typed, input t_res want);
        t_res predicted;
        push          <= 1'b1;
        i_action      <= act;
        i_index0      <= idx[0];
        i_index1      <= idx[1];
        i_index2      <= idx[2];
        i_index3      <= idx[3];
        i_write_value <= wval;
        do @(posedge i_clk); while (full);
        predicted = access_element(act, idx, wval);
        pending_results.push_back(typed ? want : predicted);
        if (predicted.status == STAT_RANGE) n_range++;
        else if (act == ACC_WRITE) n_writes++;
        else n_reads++;
    endtask

    // compare one result transfer with the oldest expectation
    function automatic void check_result();
        t_res want;
        if (pending_results.size() == 0) begin
            $error("result transfer with no access outstanding");
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (o_read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, o_read_value);
            mismatches++;
        end
        if (o_element_offset !== want.element_offset) begin
            $error("element_offset: expected %0d, got %0d", want.element_offset,
                   o_element_offset);
            mismatches++;
        end
        if (o_status !== want.status) begin
            $error("status: expected %b, got %b", want.status, o_status);
            mismatches++;
        end
    endfunction

    // result side: check transfers, idle at random, hold off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_result();
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // stimulus
    initial begin
        t_step             directed [$];
        t_access           act;
        t_idx_vec          idx;
        logic [ELEM_W-1:0] wval;
        logic [DCNT_W-1:0] dims_new;
        int unsigned       lens_new [NUM_DIMS];
        int unsigned       off;
        int                lim;
        int                drain_cycles;

        // mirror of the reset geometry
        dims_cfg = NUM_DIMS_RST;
        len_cfg[0] = LEN0_RST;
        for (int i = 1; i < NUM_DIMS; i++) len_cfg[i] = LEN_RST;
        derive_strides();

        // reset geometry: one dimension covering the whole store
        directed.push_back(access_step(ACC_WRITE, 0, 4095, 4095, 4095, 32'h7FFF_FFFF, 1'b1,
                           '{read_value: '0, element_offset: '0, status: STAT_OK}));
        directed.push_back(access_step(ACC_WRITE, 4095, 4095, 4095, 4095, 32'h8000_0000, 1'b1,
                           '{read_value: '0, element_offset: 12'd4095, status: STAT_OK}));
        directed.push_back(access_step(ACC_READ, 0, 0, 0, 0, '0, 1'b1,
                           '{read_value: 32'h7FFF_FFFF, element_offset: '0, status: STAT_OK}));
        directed.push_back(access_step(ACC_READ, 4095, 0, 0, 0, '0, 1'b1,
                           '{read_value: 32'h8000_0000, element_offset: 12'd4095,
                             status: STAT_OK}));
        // zero dimension count acts as one; zero length rejects every subscript
        directed.push_back(cfg_step(REG_NUM_DIMS, 32'd0));
        directed.push_back(cfg_step(REG_LEN_DIM0, 32'd0));
        directed.push_back(access_step(ACC_READ, 0, 0, 0, 0, '0, 1'b1, OUT_OF_RANGE));
        directed.push_back(access_step(ACC_WRITE, 4095, 0, 0, 0, '1, 1'b1, OUT_OF_RANGE));
        // count above the maximum, all lengths at the top: saturated strides
        directed.push_back(cfg_step(REG_LEN_DIM0, 32'd4096));
        directed.push_back(cfg_step(REG_LEN_DIM1, 32'd4096));
        directed.push_back(cfg_step(REG_LEN_DIM2, 32'd4096));
        directed.push_back(cfg_step(REG_LEN_DIM3, 32'd4096));
        directed.push_back(cfg_step(REG_NUM_DIMS, 32'd7));
        directed.push_back(access_step(ACC_WRITE, 0, 0, 0, 4095, 32'h1234_5678, 1'b1,
                           '{read_value: '0, element_offset: 12'd4095, status: STAT_OK}));
        directed.push_back(access_step(ACC_WRITE, 0, 0, 1, 0, 32'h5555_AAAA, 1'b1,
                           OUT_OF_RANGE));
        directed.push_back(access_step(ACC_WRITE, 1, 0, 0, 0, 32'hAAAA_5555, 1'b1,
                           OUT_OF_RANGE));
        directed.push_back(access_step(ACC_READ, 0, 0, 0, 4095, '0, 1'b0, '0));
        // two dimensions, offset just past the store
        directed.push_back(cfg_step(REG_NUM_DIMS, 32'd2));
        directed.push_back(cfg_step(REG_LEN_DIM1, 32'd2));
        directed.push_back(access_step(ACC_WRITE, 2048, 0, 4095, 4095, 32'h0F0F_0F0F, 1'b1,
                           OUT_OF_RANGE));
        directed.push_back(access_step(ACC_WRITE, 2047, 1, 4095, 4095, '1, 1'b0, '0));
        directed.push_back(access_step(ACC_READ, 2047, 2, 0, 0, '0, 1'b1, OUT_OF_RANGE));
        directed.push_back(access_step(ACC_READ, 0, 0, 4095, 4095, '0, 1'b0, '0));
        // three small dimensions, fourth ignored
        directed.push_back(cfg_step(REG_NUM_DIMS, 32'd3));
        directed.push_back(cfg_step(REG_LEN_DIM0, 32'd16));
        directed.push_back(cfg_step(REG_LEN_DIM1, 32'd16));
        directed.push_back(cfg_step(REG_LEN_DIM2, 32'd16));
        directed.push_back(access_step(ACC_WRITE, 15, 15, 15, 4095, 32'h0000_0000, 1'b0, '0));
        directed.push_back(access_step(ACC_READ, 15, 15, 15, 0, '0, 1'b0, '0));
        directed.push_back(access_step(ACC_READ, 16, 0, 0, 0, '0, 1'b1, OUT_OF_RANGE));
        // four dimensions with an empty last one
        directed.push_back(cfg_step(REG_LEN_DIM3, 32'd0));
        directed.push_back(cfg_step(REG_NUM_DIMS, 32'd4));
        directed.push_back(access_step(ACC_READ, 0, 0, 0, 0, '0, 1'b1, OUT_OF_RANGE));

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                write_register(directed[k].sel, directed[k].value);
            end else begin
                sender_gap();
                offer_access(directed[k].act, directed[k].idx, directed[k].wval,
                             directed[k].typed, directed[k].want);
            end
        end

        // random phases, each under its own geometry
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    dims_new = 3'd1;
                    lens_new = '{4096, 1, 1, 1};
                end
                1: begin
                    dims_new = 3'd4;
                    lens_new = '{4, 8, 16, 8};
                end
                2: begin
                    dims_new = 3'd2;
                    lens_new = '{64, 64, 1, 1};
                end
                3: begin
                    dims_new = 3'd5;
                    lens_new = '{4096, 4096, 4096, 4096};
                end
                default: begin
                    dims_new = DCNT_W'($urandom_range(0, 7));
                    for (int i = 0; i < NUM_DIMS; i++) begin
                        case ($urandom_range(0, 19))
                            0:       lens_new[i] = 0;
                            1, 2:    lens_new[i] = 4096;
                            3, 4:    lens_new[i] = 1;
                            5, 6, 7, 8, 9, 10, 11, 12:
                                     lens_new[i] = $urandom_range(2, 16);
                            13, 14, 15, 16, 17:
                                     lens_new[i] = $urandom_range(2, 128);
                            default: lens_new[i] = $urandom_range(1, 4096);
                        endcase
                    end
                end
            endcase
            for (int i = 0; i < NUM_DIMS; i++)
                write_register(LEN_REG_SEL[i], DATA_W'(lens_new[i]));
            write_register(REG_NUM_DIMS, DATA_W'(dims_new));

            // phase 1 fills the block against a stalled receiver, phase 2 runs flat out
            sender_calm   = (phase == 1) || (phase == 2);
            receiver_calm = (phase == 2);
            hold_request  = (phase == 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mid-phase pause until every result has come back
                if (phase == 4 && n == ITEMS_PER_PHASE / 2) begin
                    push <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
                act = t_access'($urandom_range(0, 1));
                for (int d = 0; d < NUM_DIMS; d++) begin
                    lim = int'(len_cfg[d]);
                    if (d < dims_in_use() && lim != 0 && $urandom_range(0, 9) != 0) begin
                        case ($urandom_range(0, 4))
                            0:       idx[d] = '0;
                            1:       idx[d] = IDX_W'(lim - 1);
                            default: idx[d] = IDX_W'($urandom_range(0, lim - 1));
                        endcase
                    end else begin
                        idx[d] = IDX_W'($urandom);
                    end
                end
                // never read an element that holds nothing yet
                if (act == ACC_READ && !map_element(idx, off) && !elem_valid[off])
                    act = ACC_WRITE;
                case ($urandom_range(0, 15))
                    0:       wval = 32'h8000_0000;
                    1:       wval = 32'h7FFF_FFFF;
                    2:       wval = '0;
                    3:       wval = '1;
                    default: wval = $urandom;
                endcase
                sender_gap();
                offer_access(act, idx, wval, 1'b0, '0);
            end
        end

        // drain and settle
        push <= 1'b0;
        sender_calm = 1'b0;
        receiver_calm = 1'b1;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("accesses: %0d reads, %0d writes, %0d out of range",
                 n_reads, n_writes, n_range);
        $display("geometry changed by %0d register writes over %0d random phases",
                 n_reg_writes, N_PHASES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
